[hdl/double_to_fixed_converter_top_defines.svh]
// assertion macros for the double to fixed converter
`ifndef DOUBLE_TO_FIXED_CONVERTER_TOP_DEFINES_SVH
`define DOUBLE_TO_FIXED_CONVERTER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define D2F_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("d2f check failed");
// next-cycle implication checked on every rising clock edge outside reset
`define D2F_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("d2f check failed");
`endif

[hdl/d2f_pkg.sv]
// shared constants and types for the double to fixed converter
`timescale 1ns / 1ps
package d2f_pkg;
  localparam int MAX_WIDTH = 64;
  localparam int WL_W = 7;
  localparam int FL_W = 6;
  localparam logic [0:0] REG_WORD_LENGTH = 1'b0;
  localparam logic [0:0] REG_FRACTION_LENGTH = 1'b1;
  localparam logic [6:0] WL_RESET = 7'd16;
  localparam logic [5:0] FL_RESET = 6'd8;

  typedef struct packed {
    logic [WL_W-1:0] word_length;
    logic [FL_W-1:0] fraction_length;
  } cfg_t;
endpackage

[hdl/d2f_cfg_regs.sv]
// configuration registers for word and fraction length
`timescale 1ns / 1ps
module d2f_cfg_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [d2f_pkg::WL_W-1:0] cfg_data,
  output d2f_pkg::cfg_t            cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.word_length <= d2f_pkg::WL_RESET;
      cfg.fraction_length <= d2f_pkg::FL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        d2f_pkg::REG_WORD_LENGTH: cfg.word_length <= cfg_data;
        d2f_pkg::REG_FRACTION_LENGTH: cfg.fraction_length <= cfg_data[d2f_pkg::FL_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

[hdl/d2f_convert.sv]
// combinational shift, round and saturate of one binary64 word
`timescale 1ns / 1ps
module d2f_convert (
  input  logic [63:0]   float_bits,
  input  d2f_pkg::cfg_t cfg,
  output logic [63:0]   fixed_value
);
  logic [6:0]  w;
  logic [63:0] mask;
  logic [63:0] half;
  logic [63:0] max_pos;
  logic        neg;
  logic [10:0] expf;
  logic [51:0] man;
  logic [52:0] sig;
  logic signed [12:0] k;
  logic [5:0]  n;
  logic [63:0] mag;
  logic [63:0] shr;
  logic        huge;
  logic        is_nan;

  always_comb begin
    w = cfg.word_length;
    if (w < 7'd2) w = 7'd2;
    if (w > 7'(d2f_pkg::MAX_WIDTH)) w = 7'(d2f_pkg::MAX_WIDTH);
    mask = (w == 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    half = 64'd1 << (w - 7'd1);
    max_pos = half - 64'd1;
    neg = float_bits[63];
    expf = float_bits[62:52];
    man = float_bits[51:0];
    is_nan = (expf == 11'h7ff) && (man != 52'd0);
    sig = (expf == 11'd0) ? {1'b0, man} : {1'b1, man};
    k = (expf == 11'd0) ? -13'sd1074 : ($signed({2'b00, expf}) - 13'sd1075);
    k = k + $signed({7'd0, cfg.fraction_length});
    huge = 1'b0;
    mag = '0;
    n = '0;
    shr = '0;
    if (expf == 11'h7ff) begin
      huge = 1'b1;
    end else if (sig == 53'd0) begin
      mag = '0;
    end else if (k >= 13'sd11) begin
      huge = 1'b1;
    end else if (k >= 13'sd0) begin
      mag = {11'd0, sig} << k[3:0];
    end else if (k < -13'sd54) begin
      mag = '0;
    end else begin
      n = 6'(-k);
      shr = {11'd0, sig} >> (n - 6'd1);
      mag = (shr >> 1) + {63'd0, shr[0]};
    end
    if (is_nan) fixed_value = '0;
    else if (!neg) fixed_value = (huge || mag > max_pos) ? (max_pos & mask) : (mag & mask);
    else fixed_value = (huge || mag >= half) ? (half & mask) : ((64'd0 - mag) & mask);
  end
endmodule

[hdl/double_to_fixed_converter_top.sv]
// Double to fixed converter top level.
// Channels: s_axis (tdata = float_bits, binary64 raw bits) in,
// m_axis (tdata = fixed_value, code in low word_length bits) out.
// Config: cfg_we/cfg_index/cfg_data; index 0 word_length, 1 fraction_length,
// the user writes them only while the block is idle; it does not enforce this.
// Path: accepted word to input register, converted result to result register.
// Throughput: one word per cycle while the receiver does not stall, set by
// the single input and result registers around the convert logic.
// The input stage loads whenever it is empty or the result stage moves on,
// so a full pipe of two words holds while the receiver stalls and
// s_axis_tready drops only when both stages are full and m_axis_tready is low.
// Reset empties both stages and sets word_length 16, fraction_length 8.
// Results come out in order, one per accepted word.
`timescale 1ns / 1ps
`include "double_to_fixed_converter_top_defines.svh"
module double_to_fixed_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // float_bits[63:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // fixed_value[63:0]
);
  d2f_pkg::cfg_t cfg;
  logic        in_valid;
  logic [63:0] in_bits;
  logic [63:0] conv;
  logic        out_move;

  d2f_cfg_regs u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  d2f_convert u_conv (.float_bits(in_bits), .cfg, .fixed_value(conv));

  assign out_move = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_move) m_axis_tvalid <= in_valid;
      if (s_axis_tready) in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_bits <= s_axis_tdata;
    if (out_move && in_valid) m_axis_tdata <= conv;
  end

  `D2F_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `D2F_ASSERT_IMP(a_ready_full, !s_axis_tready, in_valid && m_axis_tvalid)
  `D2F_ASSERT_NEXT(a_in_to_out, in_valid && out_move, m_axis_tvalid)
endmodule

[tb/tb_double_to_fixed_converter_top.sv]
// self-checking testbench for the double to fixed converter: directed and random conversions
`timescale 1ns / 1ps
module tb_double_to_fixed_converter_top;
  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // float_bits[63:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // fixed_value[63:0]

  logic [6:0] word_len;
  logic [5:0] frac_len;
  logic [63:0] fixed_q[$];
  int errors;
  bit stalls_on;

  double_to_fixed_converter_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] to_fixed(input logic [63:0] bits);
    int unsigned w;
    logic [63:0] mask, half, max_pos, sig, mag;
    logic neg, huge;
    logic [10:0] expf;
    int k;
    w = word_len < 2 ? 2 : (word_len > d2f_pkg::MAX_WIDTH ? d2f_pkg::MAX_WIDTH : word_len);
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 1);
    half = 64'd1 << (w - 1);
    max_pos = half - 1;
    neg = bits[63];
    expf = bits[62:52];
    mag = '0;
    huge = 1'b0;
    if (expf == 11'h7ff) begin
      if (bits[51:0] != 0) return '0;
      huge = 1'b1;
    end else begin
      if (expf == 0) begin
        sig = {12'd0, bits[51:0]};
        k = -1074;
      end else begin
        sig = {11'd0, 1'b1, bits[51:0]};
        k = int'(expf) - 1075;
      end
      k += frac_len;
      if (sig == 0) mag = '0;
      else if (k >= 11) huge = 1'b1;
      else if (k >= 0) mag = sig << k;
      else if (-k > 54) mag = '0;
      else mag = (sig >> (-k)) + ((sig >> (-k - 1)) & 64'd1);
    end
    if (!neg) return ((huge || mag > max_pos) ? max_pos : mag) & mask;
    return ((huge || mag >= half) ? half : (64'd0 - mag)) & mask;
  endfunction

  // result checker and receiver stalls
  initial begin
    int gap;
    logic [63:0] want;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if (fixed_q.size() == 0) begin
          $error("fixed_value: unexpected word %h", m_axis_tdata);
          errors++;
        end else begin
          want = fixed_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("fixed_value: expected %h actual %h", want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (stalls_on && m_axis_tready && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [63:0] bits);
    int gap;
    if (stalls_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= bits;
    fixed_q.push_back(to_fixed(bits));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (fixed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == d2f_pkg::REG_WORD_LENGTH) word_len = val;
    else frac_len = val[5:0];
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: b[62:52] = '0;
      1: b[62:52] = '1;
      2, 3, 4: b[62:52] = 11'(11'd1023 + $urandom_range(0, 70) - 60);
      5: b[62:52] = 11'(11'd1023 - $urandom_range(0, 8));
      default: ;
    endcase
    return b;
  endfunction

  task automatic test_directed();
    logic [63:0] vals[$];
    vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
             64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
             64'hfff0_0000_0000_0001, 64'h0000_0000_0000_0001,
             64'h800f_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
             64'hbff0_0000_0000_0000, 64'h3fe0_0000_0000_0000,
             64'hbfe0_0000_0000_0000, 64'h405f_c000_0000_0000,
             64'hc060_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
             64'hffef_ffff_ffff_ffff, 64'h3f70_0000_0000_0000,
             64'h3f60_0000_0000_0000, 64'hbf60_0000_0000_0000,
             64'h4060_0000_0000_0000, 64'hffff_ffff_ffff_ffff};
    foreach (vals[i]) send_word(vals[i]);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [6:0] wls[$];
    logic [5:0] fls[$];
    wls = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd33, 7'd8};
    fls = '{6'd0, 6'd63, 6'd1, 6'd31, 6'd10, 6'd7};
    foreach (wls[i]) begin
      write_reg(d2f_pkg::REG_WORD_LENGTH, wls[i]);
      write_reg(d2f_pkg::REG_FRACTION_LENGTH, {1'b0, fls[i]});
      repeat (150) send_word(rand_double());
      drain();
    end
  endtask

  task automatic test_random();
    repeat (6) begin
      write_reg(d2f_pkg::REG_WORD_LENGTH, 7'($urandom_range(0, 127)));
      write_reg(d2f_pkg::REG_FRACTION_LENGTH, 7'($urandom_range(0, 63)));
      repeat (100) send_word(rand_double());
      drain();
    end
  endtask

  task automatic test_no_idle();
    stalls_on = 1'b0;
    write_reg(d2f_pkg::REG_WORD_LENGTH, 7'd64);
    write_reg(d2f_pkg::REG_FRACTION_LENGTH, 7'd32);
    repeat (200) send_word(rand_double());
    drain();
  endtask

  initial begin
    errors = 0;
    stalls_on = 1'b1;
    word_len = d2f_pkg::WL_RESET;
    frac_len = d2f_pkg::FL_RESET;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    test_no_idle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/d2f_pkg.sv
hdl/d2f_cfg_regs.sv
hdl/d2f_convert.sv
hdl/double_to_fixed_converter_top.sv
tb/tb_double_to_fixed_converter_top.sv
